// ===== rtl/lpd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpd_pkg - shared definitions for the length-prefixed deframer
// Phase and result codes, header layout and field widths.
// ----------------------------------------------------------------------------
package lpd_pkg;

  localparam int unsigned DATA_W  = 8;
  localparam int unsigned TYPE_W  = 16;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned SEQ_W   = 32;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned PHASE_W = 2;
  localparam int unsigned CNT_W   = 4;

  // Header byte positions: type 0..1, length 2..3, sequence 4..7, stamp 8..11
  localparam logic [CNT_W-1:0] HDR_LEN_POS   = 4'd2;
  localparam logic [CNT_W-1:0] HDR_SEQ_POS   = 4'd4;
  localparam logic [CNT_W-1:0] HDR_STAMP_POS = 4'd8;
  localparam logic [CNT_W-1:0] HDR_LAST_POS  = 4'd11;

  localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = 16'd4096;

  localparam logic [PHASE_W-1:0] PH_HEADER  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_PAYLOAD = 2'd1;
  localparam logic [PHASE_W-1:0] PH_HALT    = 2'd2;

  localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

endpackage

// ===== rtl/length_prefixed_deframer.sv =====
// Timing: a result is registered and appears on out_* in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle; the input is stalled only while a result waits
//   in the output register and the sink stalls it.
// Reset (rst_n low, synchronous): header collection, counters and fields cleared,
//   max_payload back to 4096, output register empty.
// ----------------------------------------------------------------------------
// length_prefixed_deframer - streaming deframer for length-prefixed messages
// Gathers a 12-byte big-endian header (type, length, sequence, timestamp),
// emits a header result, then passes payload bytes through one per beat.
// An oversize length emits one error result and halts until reset.
// ----------------------------------------------------------------------------
module length_prefixed_deframer
  import lpd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // configuration write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [LEN_W-1:0]    cfg_max_payload,
  // byte input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [DATA_W-1:0]   in_data_byte,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [KIND_W-1:0]   out_result_kind,
  output logic [TYPE_W-1:0]   out_message_type,
  output logic [LEN_W-1:0]    out_payload_length,
  output logic [SEQ_W-1:0]    out_sequence_number,
  output logic [STAMP_W-1:0]  out_time_stamp,
  output logic [DATA_W-1:0]   out_payload_byte,
  output logic                out_last_of_message
);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  logic [LEN_W-1:0]   max_payload_r;
  logic [PHASE_W-1:0] phase_r,  phase_nxt;
  logic [CNT_W-1:0]   cnt_r,    cnt_nxt;
  logic [TYPE_W-1:0]  type_r,   type_nxt;
  logic [LEN_W-1:0]   len_r,    len_nxt;
  logic [SEQ_W-1:0]   seq_r,    seq_nxt;
  logic [STAMP_W-DATA_W-1:0] stamp_r, stamp_nxt;  // first three stamp bytes
  logic [LEN_W-1:0]   rem_r,    rem_nxt;          // payload bytes still to pass

  // result register
  logic               ov_r,     ov_nxt;
  logic [KIND_W-1:0]  okind_r;
  logic [TYPE_W-1:0]  otype_r;
  logic [LEN_W-1:0]   olen_r;
  logic [SEQ_W-1:0]   oseq_r;
  logic [STAMP_W-1:0] ostamp_r;
  logic [DATA_W-1:0]  obyte_r;
  logic               olast_r;

  // result computed from the current beat
  logic               res_fire;
  logic [KIND_W-1:0]  res_kind;
  logic [LEN_W-1:0]   res_len;
  logic [STAMP_W-1:0] res_stamp;
  logic               res_last;

  logic               in_accept;
  logic               slot_free;

  // The output register takes a new result when it is empty or being drained.
  assign slot_free = !ov_r || !out_stall;
  assign in_stall  = !slot_free;
  assign in_accept = in_valid && slot_free;
  assign cfg_ready = 1'b1;

  // Full timestamp on the twelfth header byte.
  assign res_stamp = {stamp_r, in_data_byte};

  // --------------------------------------------------------------------------
  // Next-state and result logic, one beat per cycle unless the input is stalled
  // --------------------------------------------------------------------------
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    type_nxt  = type_r;
    len_nxt   = len_r;
    seq_nxt   = seq_r;
    stamp_nxt = stamp_r;
    rem_nxt   = rem_r;
    res_fire  = 1'b0;
    res_kind  = KIND_HEADER;
    res_len   = len_r;
    res_last  = 1'b0;

    if (in_accept) begin
      case (phase_r)
        PH_HEADER: begin
          if (cnt_r < HDR_LEN_POS) begin
            type_nxt = {type_r[TYPE_W-DATA_W-1:0], in_data_byte};
            cnt_nxt  = cnt_r + 1'b1;
          end else if (cnt_r < HDR_SEQ_POS) begin
            len_nxt = {len_r[LEN_W-DATA_W-1:0], in_data_byte};
            cnt_nxt = cnt_r + 1'b1;
          end else if (cnt_r < HDR_STAMP_POS) begin
            seq_nxt = {seq_r[SEQ_W-DATA_W-1:0], in_data_byte};
            cnt_nxt = cnt_r + 1'b1;
          end else if (cnt_r < HDR_LAST_POS) begin
            stamp_nxt = {stamp_r[STAMP_W-2*DATA_W-1:0], in_data_byte};
            cnt_nxt   = cnt_r + 1'b1;
          end else begin
            // header complete: length check decides the result
            cnt_nxt  = '0;
            res_fire = 1'b1;
            if (len_r > max_payload_r) begin
              phase_nxt = PH_HALT;
              res_kind  = KIND_ERROR;
              res_last  = 1'b1;
            end else if (len_r == '0) begin
              res_kind = KIND_HEADER;
              res_last = 1'b1;
            end else begin
              phase_nxt = PH_PAYLOAD;
              rem_nxt   = len_r;
              res_kind  = KIND_HEADER;
            end
          end
        end
        PH_PAYLOAD: begin
          res_fire = 1'b1;
          res_kind = KIND_PAYLOAD;
          rem_nxt  = rem_r - 1'b1;
          if (rem_r == LEN_W'(1)) begin
            res_last  = 1'b1;
            phase_nxt = PH_HEADER;
            cnt_nxt   = '0;
          end
        end
        default: begin
          // halted or unused code: byte is dropped
        end
      endcase
    end

    if (res_fire) begin
      ov_nxt = 1'b1;
    end else if (!out_stall) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  // --------------------------------------------------------------------------
  // Control and header registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RST;
      phase_r       <= PH_HEADER;
      cnt_r         <= '0;
      type_r        <= '0;
      len_r         <= '0;
      seq_r         <= '0;
      stamp_r       <= '0;
      rem_r         <= '0;
      ov_r          <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_payload_r <= cfg_max_payload;
      end
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      type_r  <= type_nxt;
      len_r   <= len_nxt;
      seq_r   <= seq_nxt;
      stamp_r <= stamp_nxt;
      rem_r   <= rem_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Result payload: loaded only when a new result is produced.
  always_ff @(posedge clk) begin
    if (res_fire) begin
      okind_r <= res_kind;
      olast_r <= res_last;
      if (res_kind == KIND_PAYLOAD) begin
        otype_r  <= '0;
        olen_r   <= '0;
        oseq_r   <= '0;
        ostamp_r <= '0;
        obyte_r  <= in_data_byte;
      end else begin
        otype_r  <= type_r;
        olen_r   <= res_len;
        oseq_r   <= seq_r;
        ostamp_r <= res_stamp;
        obyte_r  <= '0;
      end
    end
  end

  assign out_valid           = ov_r;
  assign out_result_kind     = okind_r;
  assign out_message_type    = otype_r;
  assign out_payload_length  = olen_r;
  assign out_sequence_number = oseq_r;
  assign out_time_stamp      = ostamp_r;
  assign out_payload_byte    = obyte_r;
  assign out_last_of_message = olast_r;

`ifndef SYNTHESIS
  // A payload phase always has at least one byte left to pass.
  a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> rem_r != '0)
    else $error("payload phase with zero bytes remaining");

  // Header counter never runs past the last header byte.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= HDR_LAST_POS)
    else $error("header counter out of range");

  // Once halted, accepted beats produce no result.
  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HALT && in_accept) |-> !res_fire)
    else $error("result produced while halted");

  // An error result leaves the block halted.
  a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (res_fire && res_kind == KIND_ERROR) |=> phase_r == PH_HALT)
    else $error("error result without halt");

  // A stalled result stays in the output register.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |=> ov_r)
    else $error("stalled result dropped");
`endif

endmodule
